FILE: src/vdhmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the two-state HMM Viterbi decoder: widths, register indexes,
// reset values, the state type, the ACS unit bundles and the cost-field selector.
// No dependencies.
package vdhmm_pkg;

   localparam int MAX_STEPS   = 64;
   localparam int STATE_COUNT = 2;
   localparam int STEP_W      = $clog2(MAX_STEPS);
   localparam int CNT_W       = $clog2(MAX_STEPS + 1);
   localparam int METRIC_W    = 24;
   localparam int COST_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int INIT_W      = 32;

   localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COSTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITION_COSTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMISSION_COSTS   = 2'd2;

   // -log2 of start (0.6, 0.4), transition (0.7 0.3 / 0.4 0.6) and
   // emission (0.9 0.1 / 0.2 0.8) probabilities, rounded to Q8.8.
   localparam logic [INIT_W-1:0]     INITIAL_COSTS_RESET    = 32'd22151357;
   localparam logic [CSR_DATA_W-1:0] TRANSITION_COSTS_RESET = 64'd53200222326423684;
   localparam logic [CSR_DATA_W-1:0] EMISSION_COSTS_RESET   = 64'd23083499356553255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_ACS,
      ST_PICK,
      ST_TB_READ,
      ST_TB_USE,
      ST_EMIT
   } vdhmm_state_type;

   typedef struct packed {
      logic [METRIC_W-1:0] addend_a;
      logic [COST_W-1:0]   addend_b;
      logic [METRIC_W-1:0] compare_with;
   } acs_op_type;

   typedef struct packed {
      logic [METRIC_W-1:0] sum;
      logic                less;
   } acs_res_type;

   // Selects one of four 16-bit cost fields packed into a 64-bit word.
   function automatic logic [COST_W-1:0] cost16(input logic [CSR_DATA_W-1:0] word,
                                                input logic [1:0] entry);
      cost16 = word[{entry, 4'b0000} +: COST_W];
   endfunction

endpackage
`default_nettype wire

FILE: src/vdhmm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the Viterbi decoder: the observation
// channel and the decoded-state channel. No dependencies.
interface vdhmm_req_if;
   logic valid;
   logic ready;
   logic symbol;
   logic final_req;

   modport source (output valid, output symbol, output final_req, input ready);
   modport sink   (input valid, input symbol, input final_req, output ready);
endinterface

interface vdhmm_rsp_if;
   logic       valid;
   logic       ready;
   logic       best_state;
   logic [5:0] step_index;
   logic       end_of_path;

   modport source (output valid, output best_state, output step_index,
                   output end_of_path, input ready);
   modport sink   (input valid, input best_state, input step_index,
                   input end_of_path, output ready);
endinterface
`default_nettype wire

FILE: src/vdhmm_acs_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared saturating adder and comparator of the Viterbi decoder.
// Depends on vdhmm_pkg.
module vdhmm_acs_unit
   import vdhmm_pkg::*;
(
   input  acs_op_type  op,
   output acs_res_type res
);

   logic [METRIC_W:0] wide_sum;

   // The carry out of the metric width means the sum passed the ceiling.
   assign wide_sum = {1'b0, op.addend_a} + {{(METRIC_W + 1 - COST_W){1'b0}}, op.addend_b};

   always_comb begin
      res.sum  = wide_sum[METRIC_W] ? METRIC_MAX : wide_sum[METRIC_W-1:0];
      res.less = res.sum < op.compare_with;
   end

endmodule
`default_nettype wire

FILE: src/viterbi_decoder_two_state_hmm.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the two-state, two-symbol HMM Viterbi decoder.
// Depends on vdhmm_pkg, vdhmm_if (vdhmm_req_if, vdhmm_rsp_if) and vdhmm_acs_unit.
//
// Each request transaction carries one observed symbol. The decoder keeps two
// 24-bit Q16.8 path metrics (negative log2 costs, saturating at all ones) and
// writes one 2-bit backpointer word per time step into a 64-entry memory. All
// arithmetic goes through a single saturating add/compare unit driven by a
// small sequencer, so the block takes one transaction at a time and drops
// ready until it is done. The first step of a sequence adds start cost plus
// emission cost per state; every later step does two additions per
// predecessor, two predecessors and two states, with the compare folded into
// the last addition of each state. A request that arrives with 64 steps
// already stored is dropped, unless it is marked final. A final request then
// picks the cheaper end state (the lower state wins a tie) and traces back
// through the remaining stored steps, in a read state and a use state per
// step, because each backpointer read from the memory is registered before use.
// The decoded path is then returned as one response transaction per time step,
// first step first, at up to one per cycle as the sink allows; the last one
// has end_of_path set. After that the metrics and the step count return to
// zero and the next request starts a new sequence. Configuration writes are
// taken in any cycle but are meant for when the block is idle; writes to
// index 3 are ignored. The backpointer memory needs no clearing pass since the
// traceback only reads steps written in the current sequence.
module viterbi_decoder_two_state_hmm
   import vdhmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   vdhmm_req_if.sink                  req_chan,
   vdhmm_rsp_if.source                rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // Sequencer state and per-transaction control.
   vdhmm_state_type state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic             sym_ff, sym_in;
   logic             fin_ff, fin_in;

   // Configuration registers.
   logic [INIT_W-1:0]     init_costs_ff, init_costs_in;
   logic [CSR_DATA_W-1:0] trans_costs_ff, trans_costs_in;
   logic [CSR_DATA_W-1:0] emit_costs_ff, emit_costs_in;

   // Metric datapath.
   logic [METRIC_W-1:0] pm0_ff, pm0_in;
   logic [METRIC_W-1:0] pm1_ff, pm1_in;
   logic [METRIC_W-1:0] acc_ff, acc_in;
   logic [METRIC_W-1:0] c0_ff, c0_in;
   logic [METRIC_W-1:0] nm0_ff, nm0_in;
   logic                bp0_ff, bp0_in;
   logic [CNT_W-1:0]    step_count_ff, step_count_in;

   // Traceback and result stage.
   logic                 cur_ff, cur_in;
   logic [STEP_W-1:0]    t_ff, t_in;
   logic [MAX_STEPS-1:0] path_ff, path_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]    out_idx_ff, out_idx_in;

   // Backpointer memory.
   logic [1:0]        bp_mem [MAX_STEPS];
   logic              bp_wr_en;
   logic [STEP_W-1:0] bp_wr_addr;
   logic [1:0]        bp_wr_data;
   logic              bp_rd_en;
   logic [1:0]        bp_rd_data_ff;

   acs_op_type  acs_op;
   acs_res_type acs_res;

   logic              req_accept;
   logic              rsp_accept;
   logic [STEP_W-1:0] last_step;
   logic              emit_done;
   logic              step_sel;
   logic              pred_sel;
   logic [METRIC_W-1:0] acs_pick;

   vdhmm_acs_unit u_acs (
      .op  (acs_op),
      .res (acs_res)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_accept           = req_chan.valid && req_chan.ready;
   assign rsp_accept           = rsp_valid_ff && rsp_chan.ready;
   assign last_step            = STEP_W'(step_count_ff - CNT_W'(1));
   assign emit_done            = rsp_accept && (out_idx_ff == last_step);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.best_state  = path_ff[0];
   assign rsp_chan.step_index  = out_idx_ff;
   assign rsp_chan.end_of_path = (out_idx_ff == last_step);

   // In the ACS phase the op counter walks next state, predecessor, then
   // the two additions (transition first, emission second).
   assign step_sel = op_ff[2];
   assign pred_sel = op_ff[1];
   assign acs_pick = acs_res.less ? acs_res.sum : c0_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (step_count_ff == CNT_W'(MAX_STEPS)) begin
                  state_in = req_chan.final_req ? ST_PICK : ST_IDLE;
               end else if (step_count_ff == '0) begin
                  state_in = ST_FIRST;
               end else begin
                  state_in = ST_ACS;
               end
            end
         end
         ST_FIRST: begin
            if (op_ff[0]) begin
               state_in = fin_ff ? ST_PICK : ST_IDLE;
            end
         end
         ST_ACS: begin
            if (op_ff == 3'd7) begin
               state_in = fin_ff ? ST_PICK : ST_IDLE;
            end
         end
         ST_PICK: begin
            state_in = (step_count_ff == CNT_W'(1)) ? ST_EMIT : ST_TB_READ;
         end
         ST_TB_READ: begin
            state_in = ST_TB_USE;
         end
         ST_TB_USE: begin
            state_in = (t_ff == STEP_W'(1)) ? ST_EMIT : ST_TB_READ;
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and next values.
   always_comb begin
      op_in          = op_ff;
      sym_in         = sym_ff;
      fin_in         = fin_ff;
      init_costs_in  = init_costs_ff;
      trans_costs_in = trans_costs_ff;
      emit_costs_in  = emit_costs_ff;
      pm0_in         = pm0_ff;
      pm1_in         = pm1_ff;
      acc_in         = acc_ff;
      c0_in          = c0_ff;
      nm0_in         = nm0_ff;
      bp0_in         = bp0_ff;
      step_count_in  = step_count_ff;
      cur_in         = cur_ff;
      t_in           = t_ff;
      path_in        = path_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_idx_in     = out_idx_ff;
      bp_wr_en       = 1'b0;
      bp_wr_addr     = step_count_ff[STEP_W-1:0];
      bp_wr_data     = 2'b00;
      bp_rd_en       = 1'b0;
      acs_op         = '0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_INITIAL_COSTS:    init_costs_in  = csr_write_data[INIT_W-1:0];
            CSR_TRANSITION_COSTS: trans_costs_in = csr_write_data;
            CSR_EMISSION_COSTS:   emit_costs_in  = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in  = '0;
               sym_in = req_chan.symbol;
               fin_in = req_chan.final_req;
            end
         end
         ST_FIRST: begin
            // Start cost plus emission cost, one state per cycle.
            acs_op.addend_a = {{(METRIC_W - COST_W){1'b0}},
                               cost16({{(CSR_DATA_W - INIT_W){1'b0}}, init_costs_ff},
                                      {1'b0, op_ff[0]})};
            acs_op.addend_b = cost16(emit_costs_ff, {op_ff[0], sym_ff});
            op_in           = op_ff + 3'd1;
            if (op_ff[0]) begin
               pm1_in        = acs_res.sum;
               bp_wr_en      = 1'b1;
               bp_wr_addr    = '0;
               bp_wr_data    = 2'b00;
               step_count_in = CNT_W'(1);
            end else begin
               pm0_in = acs_res.sum;
            end
         end
         ST_ACS: begin
            op_in = op_ff + 3'd1;
            if (!op_ff[0]) begin
               acs_op.addend_a = pred_sel ? pm1_ff : pm0_ff;
               acs_op.addend_b = cost16(trans_costs_ff, {pred_sel, step_sel});
               acc_in          = acs_res.sum;
            end else begin
               acs_op.addend_a     = acc_ff;
               acs_op.addend_b     = cost16(emit_costs_ff, {step_sel, sym_ff});
               acs_op.compare_with = c0_ff;
               if (!pred_sel) begin
                  c0_in = acs_res.sum;
               end else if (!step_sel) begin
                  nm0_in = acs_pick;
                  bp0_in = acs_res.less;
               end else begin
                  // Both states resolved: commit metrics and the backpointer word.
                  pm0_in        = nm0_ff;
                  pm1_in        = acs_pick;
                  bp_wr_en      = 1'b1;
                  bp_wr_data    = {acs_res.less, bp0_ff};
                  step_count_in = step_count_ff + CNT_W'(1);
               end
            end
         end
         ST_PICK: begin
            acs_op.addend_a     = pm1_ff;
            acs_op.addend_b     = '0;
            acs_op.compare_with = pm0_ff;
            cur_in              = acs_res.less;
            path_in             = {path_ff[MAX_STEPS-2:0], acs_res.less};
            t_in                = last_step;
            if (step_count_ff == CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = '0;
            end
         end
         ST_TB_READ: begin
            bp_rd_en = 1'b1;
         end
         ST_TB_USE: begin
            cur_in  = bp_rd_data_ff[cur_ff];
            path_in = {path_ff[MAX_STEPS-2:0], bp_rd_data_ff[cur_ff]};
            t_in    = t_ff - STEP_W'(1);
            if (t_ff == STEP_W'(1)) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               rsp_valid_in  = 1'b0;
               step_count_in = '0;
               pm0_in        = '0;
               pm1_in        = '0;
            end else if (rsp_accept) begin
               out_idx_in = out_idx_ff + STEP_W'(1);
               path_in    = {1'b0, path_ff[MAX_STEPS-1:1]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         init_costs_ff  <= INITIAL_COSTS_RESET;
         trans_costs_ff <= TRANSITION_COSTS_RESET;
         emit_costs_ff  <= EMISSION_COSTS_RESET;
         pm0_ff         <= '0;
         pm1_ff         <= '0;
         step_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_costs_ff  <= init_costs_in;
         trans_costs_ff <= trans_costs_in;
         emit_costs_ff  <= emit_costs_in;
         pm0_ff         <= pm0_in;
         pm1_ff         <= pm1_in;
         step_count_ff  <= step_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff      <= op_in;
      sym_ff     <= sym_in;
      fin_ff     <= fin_in;
      acc_ff     <= acc_in;
      c0_ff      <= c0_in;
      nm0_ff     <= nm0_in;
      bp0_ff     <= bp0_in;
      cur_ff     <= cur_in;
      t_ff       <= t_in;
      path_ff    <= path_in;
      out_idx_ff <= out_idx_in;
   end

   always_ff @(posedge clock) begin
      if (bp_wr_en) begin
         bp_mem[bp_wr_addr] <= bp_wr_data;
      end
      if (bp_rd_en) begin
         bp_rd_data_ff <= bp_mem[t_ff];
      end
   end

endmodule
`default_nettype wire

FILE: src/vdhmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the Viterbi decoder top level, and the bind that
// attaches it. Depends on viterbi_decoder_two_state_hmm and vdhmm_if.
module vdhmm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_best_state,
   input wire logic [5:0] rsp_step_index,
   input wire logic       rsp_end_of_path
);

   // A stalled response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_state)
         && $stable(rsp_step_index) && $stable(rsp_end_of_path))
      else $error("stalled response transaction changed");

   // No request is taken while a decoded path is being returned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while responses are pending");

   // A path always starts at time step zero.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_step_index == 6'd0)
      else $error("path did not start at step zero");

   // Steps of a path come in order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end_of_path |=>
         rsp_valid && rsp_step_index == $past(rsp_step_index) + 6'd1)
      else $error("step index did not advance by one");

   // The response stream stops after the last step of a path.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_path |=> !rsp_valid)
      else $error("response after end of path");

endmodule

bind viterbi_decoder_two_state_hmm vdhmm_checker u_vdhmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_best_state  (rsp_chan.best_state),
   .rsp_step_index  (rsp_chan.step_index),
   .rsp_end_of_path (rsp_chan.end_of_path)
);
`default_nettype wire

FILE: verif/viterbi_decoder_two_state_hmm_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-state HMM Viterbi decoder: it drives observation
// transactions and register writes, predicts each decoded path and checks every state result.
// Depends on vdhmm_pkg, vdhmm_if and the viterbi_decoder_two_state_hmm RTL.
module viterbi_decoder_two_state_hmm_tb;
   import vdhmm_pkg::*;

   // The reserved register index; the decoder must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_INDEX = 2'd3;

   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 12;
   // This pause outlasts a non-final step and the return to idle after the last
   // emitted state, so it covers any work that produces no result.
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 250;
   // Far beyond the slowest legal run.
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct packed {
      logic       best_state;
      logic [5:0] step_index;
      logic       end_of_path;
   } decoded_state_type;

   typedef enum {
      RX_OPEN,
      RX_LIGHT_STALL,
      RX_HEAVY_STALL
   } rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   vdhmm_req_if req_if ();
   vdhmm_rsp_if rsp_if ();

   viterbi_decoder_two_state_hmm u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the cost registers, updated whenever the testbench writes one.
   logic [INIT_W-1:0]     initial_cost_reg    = INITIAL_COSTS_RESET;
   logic [CSR_DATA_W-1:0] transition_cost_reg = TRANSITION_COSTS_RESET;
   logic [CSR_DATA_W-1:0] emission_cost_reg   = EMISSION_COSTS_RESET;

   // Shadow copy of the decoder state: the two path metrics, the backpointer word of
   // every stored step and the number of steps stored in the current sequence.
   logic [METRIC_W-1:0] metric_est [STATE_COUNT];
   logic [1:0]          backptr_est [MAX_STEPS];
   int                  steps_held;

   // Decoded states that the decoder still owes, oldest first.
   decoded_state_type pending_states [$];

   int mismatch_count        = 0;
   int observations_accepted = 0;
   int observations_dropped  = 0;
   int sequences_decoded     = 0;
   int results_checked       = 0;
   int register_writes       = 0;

   // Sender burst state and receiver stall state.
   int          burst_left      = 0;
   rx_mode_type rx_mode         = RX_OPEN;
   int          rx_mode_left    = 0;
   int          rx_hold_left    = 0;
   int          rx_hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------------

   // One 16-bit Q8.8 cost out of a packed register word.
   function automatic logic [COST_W-1:0] cost_at(input logic [CSR_DATA_W-1:0] word,
                                                 input int entry);
      return word[entry*COST_W +: COST_W];
   endfunction

   // Metric sums clamp at all ones instead of wrapping.
   function automatic logic [METRIC_W-1:0] add_saturating(input logic [METRIC_W-1:0] a,
                                                          input logic [METRIC_W-1:0] b);
      logic [METRIC_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[METRIC_W] ? METRIC_MAX : total[METRIC_W-1:0];
   endfunction

   // Advances the shadow decoder by one accepted observation. A final observation
   // traces the stored steps back and queues the decoded states, first step first.
   function automatic void predict_observation(input logic sym, input logic fin);
      logic [METRIC_W-1:0] next_metric [STATE_COUNT];
      logic [METRIC_W-1:0] via_zero;
      logic [METRIC_W-1:0] via_one;
      logic [METRIC_W-1:0] emit;
      logic [1:0]          choice;
      logic                path_state [MAX_STEPS];
      logic                cur;
      int                  n;
      decoded_state_type   item;

      observations_accepted++;
      if (steps_held < MAX_STEPS) begin
         if (steps_held == 0) begin
            // First step of a sequence: start cost plus emission cost, no predecessor.
            for (int s = 0; s < STATE_COUNT; s++) begin
               metric_est[s] = add_saturating(
                  METRIC_W'(cost_at(CSR_DATA_W'(initial_cost_reg), s)),
                  METRIC_W'(cost_at(emission_cost_reg, s * 2 + sym)));
            end
            backptr_est[0] = '0;
         end else begin
            choice = '0;
            for (int s = 0; s < STATE_COUNT; s++) begin
               emit     = METRIC_W'(cost_at(emission_cost_reg, s * 2 + sym));
               via_zero = add_saturating(add_saturating(metric_est[0],
                             METRIC_W'(cost_at(transition_cost_reg, s))), emit);
               via_one  = add_saturating(add_saturating(metric_est[1],
                             METRIC_W'(cost_at(transition_cost_reg, 2 + s))), emit);
               // State 1 wins only when strictly cheaper, so a tie goes to state 0.
               if (via_one < via_zero) begin
                  next_metric[s] = via_one;
                  choice[s]      = 1'b1;
               end else begin
                  next_metric[s] = via_zero;
               end
            end
            metric_est              = next_metric;
            backptr_est[steps_held] = choice;
         end
         steps_held++;
      end else begin
         // The store is full: the symbol is not added, but a final flag still counts.
         observations_dropped++;
      end

      if (fin) begin
         n                = steps_held;
         cur              = (metric_est[1] < metric_est[0]);
         path_state[n-1]  = cur;
         for (int t = n - 1; t > 0; t--) begin
            cur             = backptr_est[t][cur];
            path_state[t-1] = cur;
         end
         for (int t = 0; t < n; t++) begin
            item.best_state  = path_state[t];
            item.step_index  = 6'(t);
            item.end_of_path = (t == n - 1);
            pending_states   = {pending_states, item};
         end
         steps_held = 0;
         for (int s = 0; s < STATE_COUNT; s++) begin
            metric_est[s] = '0;
         end
         sequences_decoded++;
      end
   endfunction

   // ------------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------------

   function automatic void report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      $display("%0t ns: %s differs: expected %0d, actual %0d", $time, what, want, got);
   endfunction

   function automatic void check_decoded_state();
      decoded_state_type want;
      results_checked++;
      if (pending_states.size() == 0) begin
         mismatch_count++;
         $display("%0t ns: unexpected state result: expected none, actual step %0d state %0d",
                  $time, rsp_if.step_index, rsp_if.best_state);
      end else begin
         want = pending_states.pop_front();
         if (rsp_if.best_state !== want.best_state) begin
            report_mismatch($sformatf("best_state of step %0d", want.step_index),
                            want.best_state, rsp_if.best_state);
         end
         if (rsp_if.step_index !== want.step_index) begin
            report_mismatch("step_index", want.step_index, rsp_if.step_index);
         end
         if (rsp_if.end_of_path !== want.end_of_path) begin
            report_mismatch($sformatf("end_of_path of step %0d", want.step_index),
                            want.end_of_path, rsp_if.end_of_path);
         end
      end
   endfunction

   // Both channels are sampled at the rising edge. A result is always checked before
   // the observation of the same edge is predicted; the decoder holds one transaction
   // at a time, so a result never depends on an observation taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_decoded_state();
         end
         if (req_if.valid && req_if.ready) begin
            predict_observation(req_if.symbol, req_if.final_req);
         end
      end
   end

   // ------------------------------------------------------------------------------
   // Receiver: changes ready at the falling edge. It switches between open, lightly
   // stalled and heavily stalled stretches, and honors a requested long hold-off.
   // ------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rx_hold_request > 0) begin
         rx_hold_left    = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(8, 40);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_OPEN: begin
               rsp_if.ready <= 1'b1;
            end
            RX_LIGHT_STALL: begin
               rsp_if.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------------
   // Sender and register access. Every task is entered and left at a falling edge.
   // ------------------------------------------------------------------------------

   // Offers one observation and waits until it is accepted. Between bursts of random
   // length the sender may drop valid for a random gap; inside a burst valid stays high.
   task automatic send_observation(input logic sym, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.symbol    <= sym;
      req_if.final_req <= fin;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      @(negedge clock);
   endtask

   // Sends a sequence whose symbols are taken from the pattern, bit 0 first.
   task automatic send_sequence(input logic [MAX_STEPS-1:0] pattern, input int length);
      for (int i = 0; i < length; i++) begin
         send_observation(pattern[i], i == length - 1);
      end
   endtask

   task automatic send_random_sequence(input int length);
      for (int i = 0; i < length; i++) begin
         send_observation(1'($urandom_range(0, 1)), i == length - 1);
      end
   endtask

   // Stops offering and waits until every owed state has arrived, then lets the
   // decoder finish any step that produces no result.
   task automatic drain_decoder();
      req_if.valid <= 1'b0;
      while (pending_states.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_INITIAL_COSTS:    initial_cost_reg    = value[INIT_W-1:0];
         CSR_TRANSITION_COSTS: transition_cost_reg = value;
         CSR_EMISSION_COSTS:   emission_cost_reg   = value;
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
   endtask

   task automatic apply_costs(input logic [CSR_DATA_W-1:0] init_word,
                              input logic [CSR_DATA_W-1:0] trans_word,
                              input logic [CSR_DATA_W-1:0] emis_word);
      drain_decoder();
      write_register(CSR_INITIAL_COSTS, init_word);
      write_register(CSR_TRANSITION_COSTS, trans_word);
      write_register(CSR_EMISSION_COSTS, emis_word);
   endtask

   // Each cost field is zero, all ones, a small value (close races and ties) or fully
   // random. The upper half of a start-cost word is junk that the decoder must drop.
   function automatic logic [CSR_DATA_W-1:0] random_cost_word();
      logic [CSR_DATA_W-1:0] word;
      for (int f = 0; f < 4; f++) begin
         case ($urandom_range(0, 5))
            0:       word[f*COST_W +: COST_W] = '0;
            1:       word[f*COST_W +: COST_W] = '1;
            2:       word[f*COST_W +: COST_W] = COST_W'($urandom_range(0, 1024));
            default: word[f*COST_W +: COST_W] = COST_W'($urandom);
         endcase
      end
      return word;
   endfunction

   // Rewrites a random subset of the cost registers between two sequences.
   task automatic randomize_costs();
      drain_decoder();
      if ($urandom_range(0, 2) != 0) write_register(CSR_INITIAL_COSTS, random_cost_word());
      if ($urandom_range(0, 2) != 0) write_register(CSR_TRANSITION_COSTS, random_cost_word());
      if ($urandom_range(0, 2) != 0) write_register(CSR_EMISSION_COSTS, random_cost_word());
   endtask

   // ------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------

   // Decoding with the reset costs: single-step sequences for both symbols, where the
   // path is just the cheaper first-step state, and a short mixed sequence.
   task automatic test_reset_costs();
      send_sequence(64'b0, 1);
      send_sequence(64'b1, 1);
      send_sequence(64'b01101, 5);
   endtask

   // With every cost equal each comparison ties, so state 0 must win everywhere,
   // including the choice of end state. A write to the reserved index changes nothing.
   task automatic test_cost_ties();
      apply_costs('0, '0, '0);
      send_sequence(64'b0110, 4);
      drain_decoder();
      write_register(CSR_RESERVED_INDEX, '1);
      send_sequence(64'b101, 3);
   endtask

   // Costs at their extremes: everything at all ones (ties again, at the largest
   // metrics), then a mix of zero and all-ones fields that forces strong decisions.
   task automatic test_cost_extremes();
      apply_costs('1, '1, '1);
      send_sequence(64'b1001, 4);
      apply_costs({32'hFFFF_FFFF, 16'h0000, 16'hFFFF},
                  {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000},
                  {16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
      send_sequence(64'b10110, 5);
   endtask

   // Fills the backpointer store. One observation past the limit is dropped and
   // the final one only starts the traceback over the full store.
   task automatic test_store_full();
      apply_costs(64'(INITIAL_COSTS_RESET), TRANSITION_COSTS_RESET, EMISSION_COSTS_RESET);
      send_random_sequence(MAX_STEPS + 2);
   endtask

   // Short random sequences, with the cost registers rewritten now and then
   // between sequences.
   task automatic test_random_sequences();
      int start_count;
      int length;
      start_count = observations_accepted - observations_dropped;
      while ((observations_accepted - observations_dropped) - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            randomize_costs();
         end
         length = $urandom_range(1, 8);
         send_random_sequence(length);
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering whole
   // sequences, so the decoder stalls on its output and then refuses new observations.
   task automatic test_output_backpressure();
      drain_decoder();
      @(posedge clock);
      rx_hold_request = HOLD_CYCLES;
      @(negedge clock);
      send_random_sequence(6);
      send_random_sequence(3);
      send_random_sequence(2);
   endtask

   // ------------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------------
   initial begin
      req_if.valid     = 1'b0;
      req_if.symbol    = 1'b0;
      req_if.final_req = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      steps_held       = 0;
      for (int s = 0; s < STATE_COUNT; s++) begin
         metric_est[s] = '0;
      end
      reset = 1'b1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_costs();
      test_cost_ties();
      test_cost_extremes();
      test_store_full();
      test_random_sequences();
      test_output_backpressure();
      drain_decoder();

      $display("Covered %0d observations (%0d dropped at a full store) in %0d sequences,",
               observations_accepted, observations_dropped, sequences_decoded);
      $display("checking %0d state results, %0d register writes and one long output hold.",
               results_checked, register_writes);
      if (mismatch_count == 0 && pending_states.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
